// File: rtl/crcan_pkg.sv
// ----------------------------------------------------------------------------
// crcan_pkg
// Shared types and constants of the circle raster canvas: request and
// response payloads, mode and register codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crcan_pkg;

  // Request modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_WIDTH      = 2'd0;
  localparam logic [1:0] REG_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_BACKGROUND = 2'd2;

  localparam logic [9:0] WIDTH_RESET      = 10'd1;
  localparam logic [9:0] HEIGHT_RESET     = 10'd1;
  localparam logic [7:0] BACKGROUND_RESET = 8'd32;

  // Q12.8 fixed point
  localparam int         FRAC_BITS = 8;
  localparam logic [19:0] ONE_Q    = 20'd256;

  typedef struct packed {
    logic [1:0]         mode;
    logic               filled;
    logic signed [19:0] center_x;
    logic signed [19:0] center_y;
    logic [19:0]        radius_q;
    logic [7:0]         paint;
    logic [8:0]         read_col;
    logic [8:0]         read_row;
  } req_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic mem_rd;
    logic deliver;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_go;
    logic read_go;
    logic sweep_last;
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/crcan_if.sv
// ----------------------------------------------------------------------------
// crcan_if
// Valid/ready channels of the circle raster canvas: one for requests and
// one for responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crcan_req_if;
  logic            valid;
  logic            ready;
  crcan_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crcan_rsp_if;
  logic            valid;
  logic            ready;
  crcan_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/crcan_ctrl.sv
// ----------------------------------------------------------------------------
// crcan_ctrl
// Request sequencer: accepts a request, picks clear/draw sweep, pixel read
// or direct reply, waits for the pixel pipeline to drain and hands off the
// response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcan_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  crcan_pkg::dp_stat_t  stat,
  output crcan_pkg::ctrl_cmd_t cmd
);

  crcan_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crcan_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      crcan_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = crcan_pkg::ST_SETUP;
        end
      end
      crcan_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        priority if (stat.sweep_go) begin
          state_next = crcan_pkg::ST_SWEEP;
        end else if (stat.read_go) begin
          state_next = crcan_pkg::ST_READ;
        end else begin
          state_next = crcan_pkg::ST_DONE;
        end
      end
      crcan_pkg::ST_SWEEP: begin
        cmd.step = 1'b1;
        if (stat.sweep_last) begin
          state_next = crcan_pkg::ST_DRAIN;
        end
      end
      crcan_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = crcan_pkg::ST_DONE;
        end
      end
      crcan_pkg::ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = crcan_pkg::ST_DONE;
      end
      crcan_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = crcan_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = crcan_pkg::ST_IDLE;
      end
    endcase
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !stat.pipe_busy)
    else $error("request taken while pixel pipeline still busy");

  a_load_to_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == crcan_pkg::ST_SETUP)
    else $error("accepted request did not enter setup");

  a_read_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> !stat.pipe_busy)
    else $error("canvas read overlaps pending pixel writes");

  a_drain_exit: assert property (@(posedge clk) disable iff (rst)
    (state == crcan_pkg::ST_DRAIN && !stat.pipe_busy) |=> state == crcan_pkg::ST_DONE)
    else $error("drain did not finish once pipeline emptied");

endmodule

// File: rtl/crcan_dp.sv
// ----------------------------------------------------------------------------
// crcan_dp
// Datapath: request latch, radius squares, pixel scan counters, three-stage
// distance pipeline, canvas memory and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcan_dp #(
  parameter int MAX_SIDE = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  crcan_pkg::req_t                     req_data,
  input  logic [$clog2(MAX_SIDE + 1) - 1:0]   w_use,
  input  logic [$clog2(MAX_SIDE + 1) - 1:0]   h_use,
  input  logic [7:0]                          background,
  input  crcan_pkg::ctrl_cmd_t                cmd,
  output crcan_pkg::dp_stat_t                 stat,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output crcan_pkg::rsp_t                     rsp_data
);

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = CW + crcan_pkg::FRAC_BITS;
  localparam int MW    = ((XW > 19) ? XW : 19) + 1;
  localparam int QW    = (2 * MW + 1 > 40) ? 2 * MW + 1 : 40;
  localparam int PW    = 9 + SW + 1;

  crcan_pkg::req_t req_q;

  logic [39:0]   r2;
  logic [39:0]   rm2;
  logic          small_r;
  logic [19:0]   rm1;
  logic [AW-1:0] raddr;
  logic [PW-1:0] raddr_full;

  logic [CW-1:0] x, y;
  logic [AW-1:0] addr;
  logic          last_x, last_y;

  logic signed [MW:0] dx_full, dy_full;
  logic [MW-1:0]      adx_c, ady_c;

  logic            v1;
  logic [MW-1:0]   adx, ady;
  logic [AW-1:0]   a1;

  logic            v2;
  logic [2*MW-1:0] dx2, dy2;
  logic [AW-1:0]   a2;

  logic [QW-1:0] d2;
  logic          in_disc, ring, is_clear, is_draw, read_hit;
  logic          we;
  logic [7:0]    wd;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;

  logic           out_valid;
  crcan_pkg::rsp_t out_data;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_data;
    end
  end

  assign is_clear = (req_q.mode == crcan_pkg::MODE_CLEAR);
  assign is_draw  = (req_q.mode == crcan_pkg::MODE_DRAW);
  assign small_r  = (req_q.radius_q < crcan_pkg::ONE_Q);
  assign rm1      = small_r ? 20'd0 : req_q.radius_q - crcan_pkg::ONE_Q;
  assign read_hit = (req_q.mode == crcan_pkg::MODE_READ)
                 && (PW'(req_q.read_col) < PW'(w_use))
                 && (PW'(req_q.read_row) < PW'(h_use));
  assign raddr_full = PW'(req_q.read_row) * PW'(w_use) + PW'(req_q.read_col);

  // Radius squares and read address
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      r2    <= 40'(req_q.radius_q) * 40'(req_q.radius_q);
      rm2   <= 40'(rm1) * 40'(rm1);
      raddr <= AW'(raddr_full);
    end
  end

  // Row-major scan counters
  assign last_x = (x == CW'(w_use - 1'b1));
  assign last_y = (y == CW'(h_use - 1'b1));

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      x    <= '0;
      y    <= '0;
      addr <= '0;
    end else if (cmd.step) begin
      addr <= addr + 1'b1;
      if (last_x) begin
        x <= '0;
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end
  end

  // Stage 1: offsets from the center
  assign dx_full = $signed({{(MW + 1 - XW){1'b0}}, x, {crcan_pkg::FRAC_BITS{1'b0}}})
                 - $signed({{(MW + 1 - 20){req_q.center_x[19]}}, req_q.center_x});
  assign dy_full = $signed({{(MW + 1 - XW){1'b0}}, y, {crcan_pkg::FRAC_BITS{1'b0}}})
                 - $signed({{(MW + 1 - 20){req_q.center_y[19]}}, req_q.center_y});
  assign adx_c = dx_full[MW] ? MW'(-dx_full) : MW'(dx_full);
  assign ady_c = dy_full[MW] ? MW'(-dy_full) : MW'(dy_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.step;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      adx <= adx_c;
      ady <= ady_c;
      a1  <= addr;
    end
    // Stage 2: squares
    dx2 <= (2 * MW)'(adx) * (2 * MW)'(adx);
    dy2 <= (2 * MW)'(ady) * (2 * MW)'(ady);
    a2  <= a1;
  end

  // Stage 3: disc / ring test and canvas write
  assign d2      = QW'(dx2) + QW'(dy2);
  assign in_disc = (d2 <= QW'(r2));
  assign ring    = in_disc && (small_r || (d2 > QW'(rm2)));
  assign we      = v2 && (is_clear || (req_q.filled ? in_disc : ring));
  assign wd      = is_clear ? background : req_q.paint;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[a2] <= wd;
    end
    if (cmd.mem_rd) begin
      rd_q <= mem[raddr];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_data.pixel  <= read_hit ? rd_q : 8'd0;
      out_data.status <= is_draw && (req_q.radius_q == 20'd0);
    end
  end

  assign rsp_valid = out_valid;
  assign rsp_data  = out_data;

  assign stat.sweep_go   = is_clear || (is_draw && (req_q.radius_q != 20'd0));
  assign stat.read_go    = read_hit;
  assign stat.sweep_last = last_x && last_y;
  assign stat.pipe_busy  = v1 || v2;
  assign stat.out_free   = !out_valid || rsp_ready;

endmodule

// File: rtl/circle_raster_canvas_unit.sv
// ----------------------------------------------------------------------------
// circle_raster_canvas_unit
// Clear and draw visit all w*h canvas pixels, one pixel per cycle (w, h =
//   width and height in use); read fetches one pixel, other requests reply
//   directly.
// Throughput: one request in flight; a new request is taken only once the
//   last response has been handed to the response register.
// Reset: control and configuration (width 1, height 1, background 32) clear
//   at once; the canvas memory is not initialized and holds no valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_raster_canvas_unit #(
  parameter int MAX_SIDE = 512
) (
  input  logic               clk,
  input  logic               rst,
  crcan_req_if.sink          req,
  crcan_rsp_if.source        rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SW = $clog2(MAX_SIDE + 1);

  // Configuration registers
  logic [9:0] canvas_width;
  logic [9:0] canvas_height;
  logic [7:0] background;

  // Sides in use, saturated to 1..MAX_SIDE
  logic [SW-1:0] w_use;
  logic [SW-1:0] h_use;

  crcan_pkg::ctrl_cmd_t cmd;
  crcan_pkg::dp_stat_t  stat;

  // APB: zero wait states; the register index sits in paddr[3:2]
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= crcan_pkg::WIDTH_RESET;
      canvas_height <= crcan_pkg::HEIGHT_RESET;
      background    <= crcan_pkg::BACKGROUND_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        crcan_pkg::REG_WIDTH:      canvas_width  <= pwdata[9:0];
        crcan_pkg::REG_HEIGHT:     canvas_height <= pwdata[9:0];
        crcan_pkg::REG_BACKGROUND: background    <= pwdata[7:0];
        default: ; // unmapped slot: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      crcan_pkg::REG_WIDTH:      prdata = {22'd0, canvas_width};
      crcan_pkg::REG_HEIGHT:     prdata = {22'd0, canvas_height};
      crcan_pkg::REG_BACKGROUND: prdata = {24'd0, background};
      default:                   prdata = 32'd0;
    endcase
  end

  // A zero side acts as one; anything past MAX_SIDE clips to it
  always_comb begin
    priority if (canvas_width == 10'd0) begin
      w_use = SW'(1);
    end else if (32'(canvas_width) > MAX_SIDE) begin
      w_use = SW'(MAX_SIDE);
    end else begin
      w_use = SW'(canvas_width);
    end
    priority if (canvas_height == 10'd0) begin
      h_use = SW'(1);
    end else if (32'(canvas_height) > MAX_SIDE) begin
      h_use = SW'(MAX_SIDE);
    end else begin
      h_use = SW'(canvas_height);
    end
  end

  // Sequencer: accept, setup, sweep or read, drain, respond
  crcan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Distance pipeline, canvas memory and response register
  crcan_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_data   (req.data),
    .w_use      (w_use),
    .h_use      (h_use),
    .background (background),
    .cmd        (cmd),
    .stat       (stat),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_data   (rsp.data)
  );

endmodule
